[design/salct_pkg.sv]
// shared constants, codes and types of the set-associative cache tracker
`default_nettype none

package salct_pkg;

  // geometry
  localparam int unsigned MAX_SETS = 64;
  localparam int unsigned MAX_WAYS = 8;
  localparam int unsigned SET_W    = $clog2(MAX_SETS);
  localparam int unsigned WAY_W    = $clog2(MAX_WAYS);

  // field widths
  localparam int unsigned ADDR_W     = 64;
  localparam int unsigned TAG_W      = 64;
  localparam int unsigned STAMP_W    = 64;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned OUTC_W     = 2;
  localparam int unsigned SB_W       = 3;
  localparam int unsigned BB_W       = 6;
  localparam int unsigned WIU_W      = 4;
  localparam int unsigned SB_MASK_W  = 1 << SB_W;
  localparam int unsigned REG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 6;

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned Q_PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

  // register reset values
  localparam logic [SB_W-1:0]  SET_BITS_RST   = SB_W'(4);
  localparam logic [BB_W-1:0]  BLOCK_BITS_RST = BB_W'(4);
  localparam logic [WIU_W-1:0] WAYS_RST       = WIU_W'(1);

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD   = 2'd0,
    CMD_STORE  = 2'd1,
    CMD_MODIFY = 2'd2,
    CMD_OTHER  = 2'd3
  } cmd_e;

  typedef enum logic [OUTC_W-1:0] {
    OUTC_HIT   = 2'd0,
    OUTC_MISS  = 2'd1,
    OUTC_EVICT = 2'd2
  } outcome_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_SET_BITS   = 2'd0,
    REG_BLOCK_BITS = 2'd1,
    REG_WAYS       = 2'd2
  } reg_e;

  typedef enum logic [1:0] {
    ST_READ,
    ST_EVAL,
    ST_WRITE
  } state_e;

  typedef struct packed {
    logic [SB_W-1:0]  set_bits;
    logic [BB_W-1:0]  block_bits;
    logic [WIU_W-1:0] ways_in_use;
  } cfg_t;

  // classified access request
  typedef struct packed {
    logic             modify;
    logic [SET_W-1:0] set_idx;
    logic [TAG_W-1:0] tag;
  } req_t;

  typedef struct packed {
    logic               vld;
    logic [TAG_W-1:0]   tag;
    logic [STAMP_W-1:0] stamp;
  } line_t;

  typedef line_t [MAX_WAYS-1:0] row_t;

  // candidate in the lru search
  typedef struct packed {
    logic               used;
    logic [WAY_W-1:0]   idx;
    logic [STAMP_W-1:0] stamp;
  } cand_t;

endpackage

`default_nettype wire

[design/salct_if.sv]
// valid/ready channel interfaces: access input, result output, register writes
`default_nettype none

interface salct_acc_if;
  import salct_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [ADDR_W-1:0] address;

  modport source (output valid, cmd, address, input ready);
  modport sink   (input valid, cmd, address, output ready);
endinterface

interface salct_res_if;
  import salct_pkg::*;
  logic              valid;
  logic              ready;
  logic [OUTC_W-1:0] outcome;
  logic              last;
  logic [CNT_W-1:0]  hit_total;
  logic [CNT_W-1:0]  miss_total;
  logic [CNT_W-1:0]  evict_total;

  modport source (output valid, outcome, last, hit_total, miss_total, evict_total,
                  input ready);
  modport sink   (input valid, outcome, last, hit_total, miss_total, evict_total,
                  output ready);
endinterface

interface salct_cfg_if;
  import salct_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [REG_IDX_W-1:0]  reg_idx;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, reg_idx, wdata, input ready);
  modport sink   (input valid, reg_idx, wdata, output ready);
endinterface

`default_nettype wire

[design/salct_front.sv]
// front end: accepts access beats, drops ignored commands, splits set index and tag
`default_nettype none

module salct_front (
  salct_acc_if.sink          acc_i,
  input  salct_pkg::cfg_t    cfg_i,
  output logic               push_valid_o,
  input  logic               push_ready_i,
  output salct_pkg::req_t    push_req_o
);
  import salct_pkg::*;

  logic [BB_W:0]         total_bits;
  logic [ADDR_W-1:0]     block_shift;
  logic [SB_MASK_W-1:0]  set_mask;

  // take a beat whenever the queue has room; ignored commands vanish here
  assign acc_i.ready  = push_ready_i;
  assign push_valid_o = acc_i.valid && (acc_i.cmd != CMD_OTHER);

  // address split
  always_comb begin
    total_bits  = (BB_W + 1)'(cfg_i.set_bits) + (BB_W + 1)'(cfg_i.block_bits);
    block_shift = acc_i.address >> cfg_i.block_bits;
    set_mask    = (SB_MASK_W'(1) << cfg_i.set_bits) - SB_MASK_W'(1);

    push_req_o.modify  = (acc_i.cmd == CMD_MODIFY);
    push_req_o.set_idx = block_shift[SET_W-1:0] & set_mask[SET_W-1:0];
    if (total_bits[BB_W]) begin
      push_req_o.tag = '0;
    end else begin
      push_req_o.tag = TAG_W'(acc_i.address >> total_bits[BB_W-1:0]);
    end
  end

endmodule

`default_nettype wire

[design/salct_queue.sv]
// short request queue between front and back end
`default_nettype none

module salct_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  salct_pkg::req_t push_req_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output salct_pkg::req_t pop_req_o
);
  import salct_pkg::*;

  req_t               entry_q [QUEUE_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [Q_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [Q_CNT_W-1:0] count_q, count_d;
  logic               push, pop;

  assign push_ready_o = (count_q != Q_CNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_req_o    = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + Q_PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + Q_PTR_W'(1);
    end
    if (push && !pop) begin
      count_d = count_q + Q_CNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_req_i;
    end
  end

endmodule

`default_nettype wire

[design/salct_back.sv]
// back end: per access reads the set row, finds hit / free way / lru way, writes back
`default_nettype none

module salct_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  salct_pkg::cfg_t cfg_i,
  input  logic            q_valid_i,
  input  salct_pkg::req_t q_req_i,
  output logic            q_ready_o,
  salct_res_if.source     res_o
);
  import salct_pkg::*;

  function automatic logic [WAY_W-1:0] first_one(input logic [MAX_WAYS-1:0] v);
    logic [WAY_W-1:0] r;
    r = '0;
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (v[i]) r = WAY_W'(i);
    end
    return r;
  endfunction

  // older stamp wins, ties keep the lower way
  function automatic cand_t older(input cand_t a, input cand_t b);
    return (b.used && (b.stamp < a.stamp)) ? b : a;
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (&v) ? v : v + CNT_W'(1);
  endfunction

  state_e               state_q, state_d;
  row_t                 row_mem [MAX_SETS];
  row_t                 rd_row_q;
  logic                 rd_init_q;
  logic [MAX_SETS-1:0]  row_init_q;
  logic [WIU_W-1:0]     ways_eff;
  logic [MAX_WAYS-1:0]  used, line_vld;
  logic [MAX_WAYS-1:0]  hit_d, hit_q, inv_d, inv_q;
  cand_t                l1_d [MAX_WAYS/2];
  cand_t                l1_q [MAX_WAYS/2];
  cand_t                cand [MAX_WAYS/2];
  logic                 second_q;
  logic [STAMP_W-1:0]   clock_q, clock_nx;
  logic [CNT_W-1:0]     hits_q, misses_q, evicts_q;
  logic [CNT_W-1:0]     hits_nx, misses_nx, evicts_nx;
  logic [WAY_W-1:0]     pick;
  outcome_e             outcome;
  row_t                 new_row;
  logic                 rd_en, wr_en, pop, out_free;
  logic                 res_valid_q;
  outcome_e             outc_q;
  logic                 last_q;
  logic [CNT_W-1:0]     hit_tot_q, miss_tot_q, evict_tot_q;

  // clamp way count to 1..MAX_WAYS
  always_comb begin
    if (cfg_i.ways_in_use == '0) begin
      ways_eff = WIU_W'(1);
    end else if (cfg_i.ways_in_use > WIU_W'(MAX_WAYS)) begin
      ways_eff = WIU_W'(MAX_WAYS);
    end else begin
      ways_eff = cfg_i.ways_in_use;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_READ:  if (q_valid_i) state_d = ST_EVAL;
      ST_EVAL:  state_d = ST_WRITE;
      ST_WRITE: if (out_free) state_d = ST_READ;
      default:  state_d = ST_READ;
    endcase
  end

  // state outputs
  always_comb begin
    out_free = !res_valid_q || res_o.ready;
    rd_en    = (state_q == ST_READ) && q_valid_i;
    wr_en    = (state_q == ST_WRITE) && out_free;
    pop      = wr_en && (!q_req_i.modify || second_q);
  end

  assign q_ready_o = pop;

  // eval: tag match, free ways and first lru level from the read row
  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      used[w]     = WIU_W'(w) < ways_eff;
      line_vld[w] = rd_row_q[w].vld && rd_init_q && used[w];
      hit_d[w]    = line_vld[w] && (rd_row_q[w].tag == q_req_i.tag);
      inv_d[w]    = used[w] && !line_vld[w];
    end
    for (int k = 0; k < MAX_WAYS / 2; k++) begin
      l1_d[k] = older('{used: used[2*k], idx: WAY_W'(2*k), stamp: rd_row_q[2*k].stamp},
                      '{used: used[2*k+1], idx: WAY_W'(2*k+1),
                        stamp: rd_row_q[2*k+1].stamp});
    end
  end

  // write-back: finish lru search, pick way, build row and counts
  always_comb begin
    for (int k = 0; k < MAX_WAYS / 2; k++) begin
      cand[k] = l1_q[k];
    end
    for (int l = 1; l < WAY_W; l++) begin
      for (int k = 0; k < (MAX_WAYS >> (l + 1)); k++) begin
        cand[k] = older(cand[2*k], cand[2*k+1]);
      end
    end

    if (|hit_q) begin
      pick    = first_one(hit_q);
      outcome = OUTC_HIT;
    end else if (|inv_q) begin
      pick    = first_one(inv_q);
      outcome = OUTC_MISS;
    end else begin
      pick    = cand[0].idx;
      outcome = OUTC_EVICT;
    end

    clock_nx = clock_q + STAMP_W'(1);
    for (int w = 0; w < MAX_WAYS; w++) begin
      new_row[w]     = rd_row_q[w];
      new_row[w].vld = rd_row_q[w].vld && rd_init_q;
    end
    new_row[pick] = '{vld: 1'b1, tag: q_req_i.tag, stamp: clock_nx};

    hits_nx   = (outcome == OUTC_HIT) ? sat_inc(hits_q) : hits_q;
    misses_nx = (outcome != OUTC_HIT) ? sat_inc(misses_q) : misses_q;
    evicts_nx = (outcome == OUTC_EVICT) ? sat_inc(evicts_q) : evicts_q;
  end

  // control and running state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_READ;
      row_init_q  <= '0;
      second_q    <= 1'b0;
      clock_q     <= '0;
      hits_q      <= '0;
      misses_q    <= '0;
      evicts_q    <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (wr_en) begin
        row_init_q[q_req_i.set_idx] <= 1'b1;
        second_q    <= !pop;
        clock_q     <= clock_nx;
        hits_q      <= hits_nx;
        misses_q    <= misses_nx;
        evicts_q    <= evicts_nx;
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // row memory, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      row_mem[q_req_i.set_idx] <= new_row;
    end
    if (rd_en) begin
      rd_row_q  <= row_mem[q_req_i.set_idx];
      rd_init_q <= row_init_q[q_req_i.set_idx];
    end
  end

  // eval stage registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_EVAL) begin
      hit_q <= hit_d;
      inv_q <= inv_d;
      for (int k = 0; k < MAX_WAYS / 2; k++) begin
        l1_q[k] <= l1_d[k];
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      outc_q      <= outcome;
      last_q      <= pop;
      hit_tot_q   <= hits_nx;
      miss_tot_q  <= misses_nx;
      evict_tot_q <= evicts_nx;
    end
  end

  assign res_o.valid       = res_valid_q;
  assign res_o.outcome     = outc_q;
  assign res_o.last        = last_q;
  assign res_o.hit_total   = hit_tot_q;
  assign res_o.miss_total  = miss_tot_q;
  assign res_o.evict_total = evict_tot_q;

endmodule

`default_nettype wire

[design/set_assoc_lru_cache_tracker.sv]
// top level: lru cache tag tracker with hit, miss and eviction counts
// flow: a taken access beat is queued, then the back end reads the set row,
//   evaluates it and writes back on the set memory and the result register (stalled
//   while the result is not taken); modify makes two passes, load/store one, ignored none
// reset: counters, access clock and registers to defaults; per-set flags mark all
//   lines invalid at once, so no clearing pass is needed
`default_nettype none

module set_assoc_lru_cache_tracker (
  input  logic        clk_i,
  input  logic        rst_ni,
  salct_acc_if.sink   acc_i,
  salct_res_if.source res_o,
  salct_cfg_if.sink   cfg_i
);
  import salct_pkg::*;

  cfg_t cfg_q;
  logic q_push_valid, q_push_ready;
  logic q_pop_valid, q_pop_ready;
  req_t push_req, pop_req;

  // register writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.set_bits    <= SET_BITS_RST;
      cfg_q.block_bits  <= BLOCK_BITS_RST;
      cfg_q.ways_in_use <= WAYS_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.reg_idx)
        REG_SET_BITS:   cfg_q.set_bits    <= cfg_i.wdata[SB_W-1:0];
        REG_BLOCK_BITS: cfg_q.block_bits  <= cfg_i.wdata[BB_W-1:0];
        REG_WAYS:       cfg_q.ways_in_use <= cfg_i.wdata[WIU_W-1:0];
        default: ;
      endcase
    end
  end

  salct_front u_front (
    .acc_i        (acc_i),
    .cfg_i        (cfg_q),
    .push_valid_o (q_push_valid),
    .push_ready_i (q_push_ready),
    .push_req_o   (push_req)
  );

  salct_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (q_push_valid),
    .push_ready_o (q_push_ready),
    .push_req_i   (push_req),
    .pop_valid_o  (q_pop_valid),
    .pop_ready_i  (q_pop_ready),
    .pop_req_o    (pop_req)
  );

  salct_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_valid_i (q_pop_valid),
    .q_req_i   (pop_req),
    .q_ready_o (q_pop_ready),
    .res_o     (res_o)
  );

  // evictions are counted among misses
  a_miss_covers_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.miss_total >= res_o.evict_total))
    else $error("eviction count exceeds miss count");

  // retiring a request always leaves its final result in the output register
  a_retire_loads_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop_valid && q_pop_ready) |=> res_o.valid)
    else $error("request retired without a result");

  // an accepted access beat is queued
  a_access_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_i.valid && acc_i.ready && (acc_i.cmd != CMD_OTHER)) |=> q_pop_valid)
    else $error("accepted access missing from queue");

endmodule

`default_nettype wire
